// ===== rtl/bor_pkg.sv =====
// bor_pkg: shared types, widths and helpers for the box overlap resolver.
// No dependencies; used by every module under rtl/.
package bor_pkg;

    localparam int POS_W       = 24;           // signed center coordinate
    localparam int SIZE_W      = 23;           // unsigned full size
    localparam int DIFF_W      = POS_W + 1;    // center difference / magnitude
    localparam int SUM_W       = POS_W + 2;    // push-out sums before saturation
    localparam int SIDE_W      = 3;
    localparam int IN_FIELDS_W = 4 * POS_W + 4 * SIZE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * POS_W;
    localparam int OUT_TUSER_W = 1 + SIDE_W;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [SIDE_W-1:0] {
        SIDE_NONE  = 3'd0,
        SIDE_UP    = 3'd1,
        SIDE_DOWN  = 3'd2,
        SIDE_LEFT  = 3'd3,
        SIDE_RIGHT = 3'd4
    } t_side;

    // one input beat, unpacked
    typedef struct packed {
        logic signed [POS_W-1:0] self_x;
        logic signed [POS_W-1:0] self_y;
        logic [SIZE_W-1:0]       self_width;
        logic [SIZE_W-1:0]       self_height;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic [SIZE_W-1:0]       other_width;
        logic [SIZE_W-1:0]       other_height;
    } t_box;

    // per-stage load enables from the top-level flow control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // geometry handed from bor_geom to bor_push
    typedef struct packed {
        logic [DIFF_W-1:0]       adx;     // |other_x - self_x|
        logic [DIFF_W-1:0]       ady;
        logic                    xneg;
        logic                    xzero;
        logic                    yneg;
        logic                    yzero;
        logic [SIZE_W-1:0]       hw;      // sum of half widths
        logic [SIZE_W-1:0]       hh;      // sum of half heights
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
    } t_geom;

    // clamp a push-out sum to the coordinate range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:POS_W-1];
        all_zero = ~|v[SUM_W-1:POS_W-1];
        if (all_one || all_zero) begin
            sat_pos = v[POS_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_pos = POS_MIN;
        end else begin
            sat_pos = POS_MAX;
        end
    endfunction

endpackage

// ===== rtl/box_overlap_resolve.sv =====
// box_overlap_resolve: top level, stream ports, config register, pipeline flow control.
// Depends on bor_pkg, bor_geom, bor_push.
//
// Axis-aligned box overlap test and push-out. Each input beat carries a moving
// box and an obstacle box (centers signed, sizes unsigned, 8 fraction bits);
// each beat yields exactly one output beat in the same order, reporting hit,
// contact side and the moving center pushed flush against the obstacle
// (saturated to 24 bits). The datapath is a four-stage pipeline: differences
// and half sizes, magnitudes, overlap compare with penetrations and flush
// positions, then side choice with saturation into the output register.
// An accepted beat loads stage 1 and then moves through stages 2 and 3 into
// the output register; the pipeline takes one beat per cycle while
// m_axis_tready does not stall it. Each stage holds a valid bit and loads
// whenever it is empty or its successor moves, so bubbles collapse and new
// beats are taken while a finished result waits on m_axis_tready.
// s_axis_tready is combinational from the stage occupancy and m_axis_tready.
// edge_inclusive (reset 0) selects touching edges as overlap; write it only
// while the pipeline is empty.
module box_overlap_resolve (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config: edge_inclusive
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_wr_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: self_x[23:0], self_y[47:24], self_width[70:48],
    // self_height[93:71], other_x[117:94], other_y[141:118],
    // other_width[164:142], other_height[187:165], zero pad [191:188]
    input  logic [bor_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: new_x[23:0], new_y[47:24]
    output logic [bor_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser, low bit up: hit[0], touch_side[3:1]
    output logic [bor_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    localparam int P = bor_pkg::POS_W;
    localparam int S = bor_pkg::SIZE_W;

    logic                      r_edge_incl;
    logic [3:0]                r_valid;     // stage 1..4 occupancy in bits 0..3
    logic [3:0]                w_rdy;
    bor_pkg::t_pipe_en         w_en;
    bor_pkg::t_box             w_box;
    bor_pkg::t_geom            w_geom;
    logic                      w_hit;
    bor_pkg::t_side            w_side;
    logic signed [P-1:0]       w_new_x, w_new_y;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_incl <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_edge_incl <= i_cfg_wr_data;
        end
    end

    // beat unpack
    assign w_box.self_x       = s_axis_tdata[P-1:0];
    assign w_box.self_y       = s_axis_tdata[2*P-1:P];
    assign w_box.self_width   = s_axis_tdata[2*P+S-1:2*P];
    assign w_box.self_height  = s_axis_tdata[2*P+2*S-1:2*P+S];
    assign w_box.other_x      = s_axis_tdata[3*P+2*S-1:2*P+2*S];
    assign w_box.other_y      = s_axis_tdata[4*P+2*S-1:3*P+2*S];
    assign w_box.other_width  = s_axis_tdata[4*P+3*S-1:4*P+2*S];
    assign w_box.other_height = s_axis_tdata[4*P+4*S-1:4*P+3*S];

    // a stage can load when empty or when the next one takes its beat
    always_comb begin
        w_rdy[3] = !r_valid[3] || m_axis_tready;
        w_rdy[2] = !r_valid[2] || w_rdy[3];
        w_rdy[1] = !r_valid[1] || w_rdy[2];
        w_rdy[0] = !r_valid[0] || w_rdy[1];
        w_en.s1  = w_rdy[0] && s_axis_tvalid;
        w_en.s2  = w_rdy[1] && r_valid[0];
        w_en.s3  = w_rdy[2] && r_valid[1];
        w_en.s4  = w_rdy[3] && r_valid[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_rdy[0]) r_valid[0] <= s_axis_tvalid;
            if (w_rdy[1]) r_valid[1] <= r_valid[0];
            if (w_rdy[2]) r_valid[2] <= r_valid[1];
            if (w_rdy[3]) r_valid[3] <= r_valid[2];
        end
    end

    bor_geom u_geom (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_box  (w_box),
        .o_geom (w_geom)
    );

    bor_push u_push (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_edge_incl (r_edge_incl),
        .i_geom      (w_geom),
        .o_hit       (w_hit),
        .o_side      (w_side),
        .o_new_x     (w_new_x),
        .o_new_y     (w_new_y)
    );

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_valid[3];
    assign m_axis_tdata  = {w_new_y, w_new_x};
    assign m_axis_tuser  = {w_side, w_hit};

endmodule

// ===== rtl/bor_geom.sv =====
// bor_geom: stages 1 and 2, center differences, half-size sums and magnitudes.
// Depends on bor_pkg.
module bor_geom (
    input  logic              i_clk,
    input  bor_pkg::t_pipe_en i_en,
    input  bor_pkg::t_box     i_box,
    output bor_pkg::t_geom    o_geom
);

    logic signed [bor_pkg::DIFF_W-1:0] n_s1_dx, n_s1_dy;
    logic [bor_pkg::SIZE_W-1:0]        n_s1_hw, n_s1_hh;
    logic signed [bor_pkg::DIFF_W-1:0] r_s1_dx, r_s1_dy;
    logic [bor_pkg::SIZE_W-1:0]        r_s1_hw, r_s1_hh;
    logic signed [bor_pkg::POS_W-1:0]  r_s1_ox, r_s1_oy, r_s1_sx, r_s1_sy;
    bor_pkg::t_geom                    n_s2, r_s2;

    // stage 1: dx, dy and summed half sizes (halves truncate)
    always_comb begin
        n_s1_dx = {i_box.other_x[bor_pkg::POS_W-1], i_box.other_x}
                - {i_box.self_x[bor_pkg::POS_W-1], i_box.self_x};
        n_s1_dy = {i_box.other_y[bor_pkg::POS_W-1], i_box.other_y}
                - {i_box.self_y[bor_pkg::POS_W-1], i_box.self_y};
        n_s1_hw = bor_pkg::SIZE_W'(i_box.self_width[bor_pkg::SIZE_W-1:1])
                + bor_pkg::SIZE_W'(i_box.other_width[bor_pkg::SIZE_W-1:1]);
        n_s1_hh = bor_pkg::SIZE_W'(i_box.self_height[bor_pkg::SIZE_W-1:1])
                + bor_pkg::SIZE_W'(i_box.other_height[bor_pkg::SIZE_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_dx <= n_s1_dx;
            r_s1_dy <= n_s1_dy;
            r_s1_hw <= n_s1_hw;
            r_s1_hh <= n_s1_hh;
            r_s1_ox <= i_box.other_x;
            r_s1_oy <= i_box.other_y;
            r_s1_sx <= i_box.self_x;
            r_s1_sy <= i_box.self_y;
        end
    end

    // stage 2: magnitudes, sign flags and zero flags
    always_comb begin
        n_s2.adx   = r_s1_dx[bor_pkg::DIFF_W-1] ? -r_s1_dx : r_s1_dx;
        n_s2.ady   = r_s1_dy[bor_pkg::DIFF_W-1] ? -r_s1_dy : r_s1_dy;
        n_s2.xneg  = r_s1_dx[bor_pkg::DIFF_W-1];
        n_s2.xzero = (r_s1_dx == '0);
        n_s2.yneg  = r_s1_dy[bor_pkg::DIFF_W-1];
        n_s2.yzero = (r_s1_dy == '0);
        n_s2.hw    = r_s1_hw;
        n_s2.hh    = r_s1_hh;
        n_s2.ox    = r_s1_ox;
        n_s2.oy    = r_s1_oy;
        n_s2.sx    = r_s1_sx;
        n_s2.sy    = r_s1_sy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_geom = r_s2;

endmodule

// ===== rtl/bor_push.sv =====
// bor_push: stages 3 and 4, overlap test, side choice, push-out and saturation.
// Depends on bor_pkg; fed by bor_geom. Stage 4 is the output register.
module bor_push (
    input  logic                            i_clk,
    input  bor_pkg::t_pipe_en               i_en,
    input  logic                            i_edge_incl,
    input  bor_pkg::t_geom                  i_geom,
    output logic                            o_hit,
    output bor_pkg::t_side                  o_side,
    output logic signed [bor_pkg::POS_W-1:0] o_new_x,
    output logic signed [bor_pkg::POS_W-1:0] o_new_y
);

    logic [bor_pkg::DIFF_W-1:0]        w_hw, w_hh;
    logic                              n_s3_hit;
    logic signed [bor_pkg::SUM_W-1:0]  n_s3_penx, n_s3_peny;
    logic [bor_pkg::SUM_W-1:0]         n_s3_x_l, n_s3_x_r, n_s3_y_u, n_s3_y_d;
    logic                              r_s3_hit;
    logic signed [bor_pkg::SUM_W-1:0]  r_s3_penx, r_s3_peny;
    logic [bor_pkg::SUM_W-1:0]         r_s3_x_l, r_s3_x_r, r_s3_y_u, r_s3_y_d;
    logic                              r_s3_xneg, r_s3_xzero, r_s3_yneg, r_s3_yzero;
    logic signed [bor_pkg::POS_W-1:0]  r_s3_sx, r_s3_sy;
    bor_pkg::t_side                    n_side, w_vert, w_horiz;
    logic signed [bor_pkg::POS_W-1:0]  n_new_x, n_new_y;
    logic                              r_hit;
    bor_pkg::t_side                    r_side;
    logic signed [bor_pkg::POS_W-1:0]  r_new_x, r_new_y;

    // stage 3: overlap means |d| within the half-size sum on both axes
    always_comb begin
        w_hw = bor_pkg::DIFF_W'(i_geom.hw);
        w_hh = bor_pkg::DIFF_W'(i_geom.hh);
        if (i_edge_incl) begin
            n_s3_hit = (i_geom.adx <= w_hw) && (i_geom.ady <= w_hh);
        end else begin
            n_s3_hit = (i_geom.adx < w_hw) && (i_geom.ady < w_hh);
        end
        // corner penetration is the half-size sum minus the center distance
        n_s3_penx = bor_pkg::SUM_W'(i_geom.hw) - bor_pkg::SUM_W'(i_geom.adx);
        n_s3_peny = bor_pkg::SUM_W'(i_geom.hh) - bor_pkg::SUM_W'(i_geom.ady);
        // flush positions against each side of the obstacle
        n_s3_x_l = {{2{i_geom.ox[bor_pkg::POS_W-1]}}, i_geom.ox} + bor_pkg::SUM_W'(i_geom.hw);
        n_s3_x_r = {{2{i_geom.ox[bor_pkg::POS_W-1]}}, i_geom.ox} - bor_pkg::SUM_W'(i_geom.hw);
        n_s3_y_u = {{2{i_geom.oy[bor_pkg::POS_W-1]}}, i_geom.oy} + bor_pkg::SUM_W'(i_geom.hh);
        n_s3_y_d = {{2{i_geom.oy[bor_pkg::POS_W-1]}}, i_geom.oy} - bor_pkg::SUM_W'(i_geom.hh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_hit   <= n_s3_hit;
            r_s3_penx  <= n_s3_penx;
            r_s3_peny  <= n_s3_peny;
            r_s3_x_l   <= n_s3_x_l;
            r_s3_x_r   <= n_s3_x_r;
            r_s3_y_u   <= n_s3_y_u;
            r_s3_y_d   <= n_s3_y_d;
            r_s3_xneg  <= i_geom.xneg;
            r_s3_xzero <= i_geom.xzero;
            r_s3_yneg  <= i_geom.yneg;
            r_s3_yzero <= i_geom.yzero;
            r_s3_sx    <= i_geom.sx;
            r_s3_sy    <= i_geom.sy;
        end
    end

    // stage 4: side choice; smaller penetration wins, a tie gives none
    always_comb begin
        w_vert  = r_s3_yneg ? bor_pkg::SIDE_UP : bor_pkg::SIDE_DOWN;
        w_horiz = r_s3_xneg ? bor_pkg::SIDE_LEFT : bor_pkg::SIDE_RIGHT;
        if (!r_s3_hit) begin
            n_side = bor_pkg::SIDE_NONE;
        end else if (!r_s3_yzero) begin
            if (r_s3_xzero) begin
                n_side = w_vert;
            end else if (r_s3_penx < r_s3_peny) begin
                n_side = w_horiz;
            end else if (r_s3_penx > r_s3_peny) begin
                n_side = w_vert;
            end else begin
                n_side = bor_pkg::SIDE_NONE;
            end
        end else if (r_s3_xzero) begin
            n_side = bor_pkg::SIDE_NONE;
        end else begin
            n_side = w_horiz;
        end

        n_new_x = r_s3_sx;
        n_new_y = r_s3_sy;
        unique case (n_side)
            bor_pkg::SIDE_UP:    n_new_y = bor_pkg::sat_pos(r_s3_y_u);
            bor_pkg::SIDE_DOWN:  n_new_y = bor_pkg::sat_pos(r_s3_y_d);
            bor_pkg::SIDE_LEFT:  n_new_x = bor_pkg::sat_pos(r_s3_x_l);
            bor_pkg::SIDE_RIGHT: n_new_x = bor_pkg::sat_pos(r_s3_x_r);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_hit   <= r_s3_hit;
            r_side  <= n_side;
            r_new_x <= n_new_x;
            r_new_y <= n_new_y;
        end
    end

    assign o_hit   = r_hit;
    assign o_side  = r_side;
    assign o_new_x = r_new_x;
    assign o_new_y = r_new_y;

endmodule

// ===== rtl/bor_checker.sv =====
// bor_checker: port-level assertions for box_overlap_resolve, bound to the top.
// Depends on bor_pkg and box_overlap_resolve.
module bor_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bor_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [bor_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // a draining sink means every stage moves, so input must be open
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

    // no overlap never reports a side
    a_miss_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tuser[bor_pkg::OUT_TUSER_W-1:1] == bor_pkg::SIDE_NONE)
        else $error("side reported without hit");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight out of reset");

endmodule

bind box_overlap_resolve bor_checker u_bor_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
